FILE: rtl/bfiq_pkg.sv
// Shared types, sizes and the probe prime table for the bloom filter block.
package bfiq_pkg;

   // Filter geometry
   localparam int FILTER_BITS = 65536;
   localparam int PROBES      = 8;
   localparam int IDX_W       = $clog2(FILTER_BITS);
   localparam int ROW_BITS    = 64;
   localparam int BIT_W       = $clog2(ROW_BITS);
   localparam int ROWS        = FILTER_BITS / ROW_BITS;
   localparam int ROW_W       = $clog2(ROWS);
   localparam int PROBE_W     = $clog2(PROBES);
   localparam int KEY_WORDS   = 8;
   localparam int WORD_W      = 16;
   localparam int COUNT_W     = 4;

   // Item kinds
   localparam logic KIND_QUERY  = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [63:0] key_top;
      logic [63:0] key_next;
   } req_type;

   typedef struct packed {
      logic               present;
      logic [COUNT_W-1:0] newly_set;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } st_type;

   // Reduction prime for each probe slot
   function automatic logic [WORD_W-1:0] prime_of(input logic [2:0] sel);
      logic [WORD_W-1:0] p;
      begin
         case (sel)
            3'd0:    p = 16'd65353;
            3'd1:    p = 16'd65357;
            3'd2:    p = 16'd65371;
            3'd3:    p = 16'd65381;
            3'd4:    p = 16'd65393;
            3'd5:    p = 16'd65407;
            3'd6:    p = 16'd65413;
            3'd7:    p = 16'd65419;
            default: p = 16'd65353;
         endcase
         return p;
      end
   endfunction

endpackage

FILE: rtl/bloom_filter_insert_query.sv
// Top level of the bloom filter: probe sequencer around a single-port bit array.
//
// Input channel req_*: one beat carries kind (query or insert) and the upper
// 128 bits of a key hash as key_top and key_next. Result channel rsp_*: one
// beat per item with present (all eight probe bits were set beforehand) and
// newly_set (bits an insert changed from 0 to 1; 0 for a query or a collision).
//
// The filter lives in a 1024 x 64-bit synchronous memory with one port and a
// registered read. Each probe takes a read step and a check/write step; after
// the eight probes the finish step loads the result register, waiting there
// for rsp_ready if the previous result is still held, and the block then
// returns to idle before it can accept the next item.
//
// After reset the block sweeps the memory to zero, one row a cycle, with
// req_ready low. A result waiting in the output register does not stop the
// next item from being accepted and worked on; only the final load of that
// next result waits for rsp_ready.
module bloom_filter_insert_query (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfiq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfiq_pkg::rsp_type rsp_data
);

   // Filter memory
   logic [bfiq_pkg::ROW_BITS-1:0] mem [bfiq_pkg::ROWS];
   logic [bfiq_pkg::ROW_BITS-1:0] row_ff;
   logic                          mem_we;
   logic [bfiq_pkg::ROW_W-1:0]    mem_addr;
   logic [bfiq_pkg::ROW_BITS-1:0] mem_wdata;

   // Control and item state
   bfiq_pkg::st_type                                state_ff, state_in;
   logic [bfiq_pkg::ROW_W-1:0]                      clr_ff, clr_in;
   logic [bfiq_pkg::PROBE_W-1:0]                    probe_ff, probe_in;
   logic [bfiq_pkg::KEY_WORDS-1:0][bfiq_pkg::WORD_W-1:0] key_ff, key_in;
   logic                                            kind_ff, kind_in;
   logic                                            all_ff, all_in;
   logic [bfiq_pkg::COUNT_W-1:0]                    count_ff, count_in;
   logic                                            rsp_valid_ff, rsp_valid_in;
   bfiq_pkg::rsp_type                               rsp_ff, rsp_in;

   // Probe index datapath
   logic [bfiq_pkg::WORD_W-1:0] word;
   logic [bfiq_pkg::WORD_W-1:0] prime;
   logic [bfiq_pkg::WORD_W:0]   diff;
   logic [bfiq_pkg::IDX_W-1:0]  idx;
   logic [bfiq_pkg::BIT_W-1:0]  bit_sel;
   logic                        bit_hit;
   logic                        last_probe;
   logic                        out_free;
   logic                        do_set;

   // Select the key word and reduce it by one conditional subtract
   always_comb begin
      word    = key_ff[3'(bfiq_pkg::KEY_WORDS - 1) - 3'(probe_ff)];
      prime   = bfiq_pkg::prime_of(3'(bfiq_pkg::PROBES - 1) - 3'(probe_ff));
      diff    = {1'b0, word} - {1'b0, prime};
      idx     = diff[bfiq_pkg::WORD_W] ? word : diff[bfiq_pkg::WORD_W-1:0];
      bit_sel = idx[bfiq_pkg::BIT_W-1:0];
      bit_hit = row_ff[bit_sel];
   end

   assign last_probe = (probe_ff == bfiq_pkg::PROBE_W'(bfiq_pkg::PROBES - 1));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign do_set     = (kind_ff == bfiq_pkg::KIND_INSERT) && !bit_hit;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfiq_pkg::ST_CLEAR: begin
            if (clr_ff == bfiq_pkg::ROW_W'(bfiq_pkg::ROWS - 1)) begin
               state_in = bfiq_pkg::ST_IDLE;
            end
         end
         bfiq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bfiq_pkg::ST_READ;
            end
         end
         bfiq_pkg::ST_READ: begin
            state_in = bfiq_pkg::ST_CHECK;
         end
         bfiq_pkg::ST_CHECK: begin
            state_in = last_probe ? bfiq_pkg::ST_FINISH : bfiq_pkg::ST_READ;
         end
         bfiq_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = bfiq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfiq_pkg::ST_CLEAR;
         end
      endcase
   end

   // Outputs and datapath updates
   always_comb begin
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = idx[bfiq_pkg::IDX_W-1:bfiq_pkg::BIT_W];
      mem_wdata    = row_ff | (bfiq_pkg::ROW_BITS'(1) << bit_sel);
      clr_in       = clr_ff;
      probe_in     = probe_ff;
      key_in       = key_ff;
      kind_in      = kind_ff;
      all_in       = all_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         bfiq_pkg::ST_CLEAR: begin
            // sweep one row of zeros a cycle
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end
         bfiq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            key_in    = {req_data.key_top, req_data.key_next};
            kind_in   = req_data.kind;
            probe_in  = '0;
            all_in    = 1'b1;
            count_in  = '0;
         end
         bfiq_pkg::ST_READ: begin
            // address already driven from the probe index
         end
         bfiq_pkg::ST_CHECK: begin
            mem_we   = do_set;
            all_in   = all_ff && bit_hit;
            if (do_set && count_ff != bfiq_pkg::COUNT_W'(15)) begin
               count_in = count_ff + 1'b1;
            end
            probe_in = probe_ff + 1'b1;
         end
         bfiq_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_in.present   = all_ff;
               rsp_in.newly_set = count_ff;
               rsp_valid_in     = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfiq_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      key_ff   <= key_in;
      kind_ff  <= kind_in;
      all_ff   <= all_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   // Single-port filter memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      row_ff <= mem[mem_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A query never writes the filter
   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfiq_pkg::ST_CHECK && kind_ff == bfiq_pkg::KIND_QUERY) |-> !mem_we)
      else $error("query wrote the filter");

   // A fresh result only follows the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == bfiq_pkg::ST_FINISH)
      else $error("result raised outside finish");

   // A key already present cannot set new bits
   a_present_no_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.present && rsp_ff.newly_set != '0))
      else $error("present result reports new bits");

   // Count never exceeds the probes done
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfiq_pkg::ST_FINISH) |-> count_ff <= bfiq_pkg::COUNT_W'(bfiq_pkg::PROBES))
      else $error("newly set count out of range");

endmodule

FILE: tb/bfiq_checker.sv
// Bloom filter checker: tracks the filter, predicts each result beat and compares.
module bfiq_checker
   import bfiq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int unsigned mismatches,
   output int unsigned pending
);

   timeunit 1ns;
   timeprecision 1ps;

   // Reduction primes, entry 0 the smallest
   localparam bit [7:0][WORD_W-1:0] REDUCE_PRIMES = {
      16'd65419, 16'd65413, 16'd65407, 16'd65393,
      16'd65381, 16'd65371, 16'd65357, 16'd65353
   };

   bit          filter_map [FILTER_BITS];
   rsp_type     due_answers [$];
   int unsigned fail_tally;

   initial begin
      fail_tally = 0;
      mismatches = 0;
      pending    = 0;
   end

   // Print one line per fault and count it
   task automatic report_mismatch(input string what, input int got, input int want);
      fail_tally++;
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin : track
      bit [127:0]        hash;
      bit [WORD_W-1:0]   word;
      bit [WORD_W-1:0]   prime;
      bit [IDX_W-1:0]    slot_idx [PROBES];
      bit                all_set;
      bit [COUNT_W-1:0]  fresh;
      rsp_type           want;
      if (reset) begin
         foreach (filter_map[k]) filter_map[k] = 1'b0;
         due_answers.delete();
      end else begin
         // Work out the answer for each accepted key and update the filter copy
         if (req_valid && req_ready) begin
            hash    = {req_data.key_top, req_data.key_next};
            all_set = 1'b1;
            for (int i = 0; i < PROBES; i++) begin
               word  = hash[127 - 16 * (i % 8) -: 16];
               prime = REDUCE_PRIMES[(PROBES - 1 - i) % 8];
               if (word >= prime) word = word - prime;
               slot_idx[i] = word;
               if (!filter_map[slot_idx[i]]) all_set = 1'b0;
            end
            fresh = '0;
            if (req_data.kind == KIND_INSERT) begin
               // Earlier probes of the same insert may already have set a bit
               for (int i = 0; i < PROBES; i++) begin
                  if (!filter_map[slot_idx[i]]) begin
                     filter_map[slot_idx[i]] = 1'b1;
                     if (fresh != '1) fresh++;
                  end
               end
            end
            want.present   = all_set;
            want.newly_set = fresh;
            due_answers.push_back(want);
         end
         // Compare each result beat with the oldest answer due
         if (rsp_valid && rsp_ready) begin
            if (due_answers.size() == 0) begin
               report_mismatch("result beat with nothing due", int'(rsp_data), -1);
            end else begin
               want = due_answers.pop_front();
               if (rsp_data.present !== want.present)
                  report_mismatch("present", int'(rsp_data.present), int'(want.present));
               if (rsp_data.newly_set !== want.newly_set)
                  report_mismatch("newly_set", int'(rsp_data.newly_set),
                                  int'(want.newly_set));
            end
         end
      end
      pending    <= due_answers.size();
      mismatches <= fail_tally;
   end

endmodule

FILE: tb/tb.sv
// Bloom filter testbench top: clock, reset, key stimulus, result back-pressure and verdict.
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   import bfiq_pkg::*;

   localparam int RANDOM_ITEMS = 1200;
   localparam int STALL_LIMIT  = 4000;
   localparam int POOL_DEPTH   = 256;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   int unsigned mismatches;
   int unsigned pending;
   int unsigned idle_cycles = 0;
   bit          calm = 1'b0;
   bit [127:0]  seen_keys [$];

   bloom_filter_insert_query dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   bfiq_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Hash word biased towards the reduction band and a crowded low corner
   function automatic bit [15:0] rand_word();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(16'hFF49, 16'hFFFF));
         1:       return 16'($urandom_range(0, 63));
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // Offer one beat after an optional gap and hold it until accepted
   task automatic send_item(input logic kind, input bit [127:0] hash);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {kind, hash};
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and hold off until every answer due has come back
   task automatic await_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Remember inserted keys so that later queries and re-inserts can hit them
   task automatic note_key(input bit [127:0] hash);
      if (seen_keys.size() < POOL_DEPTH) seen_keys.push_back(hash);
      else seen_keys[$urandom_range(0, POOL_DEPTH - 1)] = hash;
   endtask

   // Result side back-pressure
   initial begin
      int run;
      int stall;
      while (reset) @(posedge clock);
      forever begin
         run = $urandom_range(1, 20);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = calm ? 0 : pick_gap();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Watchdog: end the run if no beat moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      bit [127:0] hash;
      int         roll;
      int         slot;
      logic       kind;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed keys, no idling
      calm = 1'b1;
      send_item(KIND_QUERY,  '0);
      send_item(KIND_INSERT, '0);
      send_item(KIND_QUERY,  '0);
      send_item(KIND_INSERT, '0);
      send_item(KIND_INSERT, '1);
      send_item(KIND_QUERY,  '1);
      // every word equal to its probe's prime: all reduce onto bit 0, a collision
      send_item(KIND_INSERT, 128'hFF8B_FF85_FF7F_FF71_FF65_FF5B_FF4D_FF49);
      // every word one below its prime: no reduction, eight new bits
      send_item(KIND_INSERT, 128'hFF8A_FF84_FF7E_FF70_FF64_FF5A_FF4C_FF48);
      send_item(KIND_QUERY,  128'hFF8A_FF84_FF7E_FF70_FF64_FF5A_FF4C_FF48);
      // all probes on one bit, counted once
      send_item(KIND_INSERT, {8{16'h1234}});
      // first two probes land on the same bit through the reduction
      send_item(KIND_INSERT, 128'hFF9B_0010_0777_8001_7FFE_A5A5_5A5A_0F0F);
      send_item(KIND_QUERY,  128'h0010_0010_0777_8001_7FFE_A5A5_5A5A_0F0F);
      send_item(KIND_QUERY,  128'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFE);
      send_item(KIND_INSERT, 128'hA5A5_A5A5_5A5A_5A5A_8000_0001_7FFF_FFFE);
      send_item(KIND_INSERT, 128'hA5A5_A5A5_5A5A_5A5A_8000_0001_7FFF_FFFE);
      calm = 1'b0;
      await_drain();

      // Random part: inserts, hits on known keys, near misses and crafted words
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 400 && n < 520);
         if (n == 600) await_drain();
         roll = $urandom_range(0, 99);
         if (roll < 30 || seen_keys.size() == 0) begin
            hash = {$urandom, $urandom, $urandom, $urandom};
            kind = KIND_INSERT;
         end else if (roll < 55) begin
            hash = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
            kind = KIND_QUERY;
         end else if (roll < 63) begin
            hash = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
            kind = KIND_INSERT;
         end else if (roll < 75) begin
            hash = {$urandom, $urandom, $urandom, $urandom};
            kind = KIND_QUERY;
         end else if (roll < 87) begin
            // known key with one word altered
            hash = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
            slot = $urandom_range(0, 7);
            hash[16 * slot +: 16] = rand_word();
            kind = logic'($urandom_range(0, 1));
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               hash = {8{rand_word()}};
            end else begin
               for (int w = 0; w < 8; w++) hash[16 * w +: 16] = rand_word();
            end
            kind = logic'($urandom_range(0, 1));
         end
         send_item(kind, hash);
         if (kind == KIND_INSERT) note_key(hash);
      end
      calm = 1'b0;

      await_drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: bloom_filter_insert_query.f
rtl/bfiq_pkg.sv
rtl/bloom_filter_insert_query.sv
tb/bfiq_checker.sv
tb/tb.sv
